// ===== src/e2q_pkg.sv =====
// Shared types and constants for the Euler angle to quaternion converter.
package e2q_pkg;

  // Working word for half angles, CORDIC values and products (Q2.30 plus headroom).
  typedef logic signed [33:0] word_t;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

  // Arctangent of 2^-i in half-angle units (2^30 is pi/2), rounded to nearest.
  function automatic logic signed [33:0] atan_entry(input logic [4:0] idx);
    logic signed [33:0] r;
    case (idx)
      5'd0:  r = 34'sh020000000;
      5'd1:  r = 34'sh012E4051E;
      5'd2:  r = 34'sh009FB385B;
      5'd3:  r = 34'sh0051111D4;
      5'd4:  r = 34'sh0028B0D43;
      5'd5:  r = 34'sh00145D7E1;
      5'd6:  r = 34'sh000A2F61E;
      5'd7:  r = 34'sh000517C55;
      5'd8:  r = 34'sh00028BE53;
      5'd9:  r = 34'sh000145F2F;
      5'd10: r = 34'sh0000A2F98;
      5'd11: r = 34'sh0000517CC;
      5'd12: r = 34'sh000028BE6;
      5'd13: r = 34'sh0000145F3;
      5'd14: r = 34'sh00000A2FA;
      5'd15: r = 34'sh00000517D;
      5'd16: r = 34'sh0000028BE;
      5'd17: r = 34'sh00000145F;
      5'd18: r = 34'sh000000A30;
      5'd19: r = 34'sh000000518;
      5'd20: r = 34'sh00000028C;
      5'd21: r = 34'sh000000146;
      5'd22: r = 34'sh0000000A3;
      5'd23: r = 34'sh000000051;
      5'd24: r = 34'sh000000029;
      5'd25: r = 34'sh000000014;
      5'd26: r = 34'sh00000000A;
      5'd27: r = 34'sh000000005;
      5'd28: r = 34'sh000000003;
      5'd29: r = 34'sh000000001;
      5'd30: r = 34'sh000000001;
      default: r = 34'sh000000000;
    endcase
    return r;
  endfunction

  // One CORDIC lane: the rotation state of a single angle.
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } lane_t;

  // Data handed from one cell to the next: three lanes and a valid flag.
  typedef struct packed {
    logic  valid;
    lane_t r;
    lane_t p;
    lane_t w;
  } cell_t;

endpackage

// ===== src/euler_to_quaternion.sv =====
// Top level of the Euler angle (ZYX) to unit quaternion converter.
//
//   Channel   Handshake          Payload
//   request   start / busy       roll, pitch, yaw
//   result    done (one cycle)   quat_w, quat_x, quat_y, quat_z
//
// A request is taken in every cycle; busy is held low since nothing stalls.
// The pipeline is one input register, one CORDIC cell per iteration, then four
// product, sum and rounding stages.
// The result is shown on done for exactly one cycle; the receiver cannot stall.
// Reset (rst, synchronous) clears only the valid flags in the pipeline.
module euler_to_quaternion #(
  parameter int ANGLE_WIDTH     = 16,
  parameter int OUT_WIDTH       = 16,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [ANGLE_WIDTH-1:0] roll,
  input  logic signed [ANGLE_WIDTH-1:0] pitch,
  input  logic signed [ANGLE_WIDTH-1:0] yaw,
  output logic                          done,
  output logic signed [OUT_WIDTH-1:0]   quat_w,
  output logic signed [OUT_WIDTH-1:0]   quat_x,
  output logic signed [OUT_WIDTH-1:0]   quat_y,
  output logic signed [OUT_WIDTH-1:0]   quat_z
);
  import e2q_pkg::*;

  localparam int HS = (ANGLE_WIDTH < 32) ? 31 - ANGLE_WIDTH : 0;

  // Half angle in units of 2^32 per turn; at full width the lowest bit drops.
  function automatic logic signed [33:0] half_angle(
      input logic signed [ANGLE_WIDTH-1:0] a);
    logic signed [33:0] e;
    e = 34'(a);
    if (ANGLE_WIDTH < 32) return e <<< HS;
    return e >>> 1;
  endfunction

  function automatic lane_t seed(input logic signed [ANGLE_WIDTH-1:0] a);
    lane_t l;
    l.x = CORDIC_GAIN;
    l.y = 34'sd0;
    l.z = half_angle(a);
    return l;
  endfunction

  assign busy = 1'b0;

  cell_t chain [TRIG_ITERATIONS+1];

  // Input register opens the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else begin
      chain[0].valid <= start;
    end
    chain[0].r <= seed(roll);
    chain[0].p <= seed(pitch);
    chain[0].w <= seed(yaw);
  end

  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_cell
    e2q_cordic_cell #(.STEP(i)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  e2q_combine #(.OUT_WIDTH(OUT_WIDTH)) u_combine (
    .clk    (clk),
    .rst    (rst),
    .din    (chain[TRIG_ITERATIONS]),
    .valid  (done),
    .quat_w (quat_w),
    .quat_x (quat_x),
    .quat_y (quat_y),
    .quat_z (quat_z)
  );

  // The valid flag at the chain entry follows the request in the next cycle.
  a_first_valid: assert property (@(posedge clk) disable iff (rst)
    start |=> chain[0].valid) else $error("request lost at chain entry");
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !start |=> !chain[0].valid) else $error("phantom item at chain entry");
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

endmodule

// ===== src/e2q_cordic_cell.sv =====
// One rotation-mode CORDIC cell, stepping three angle lanes by one iteration.
module e2q_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  e2q_pkg::cell_t din,
  output e2q_pkg::cell_t dout
);
  import e2q_pkg::*;

  localparam logic [4:0] SHIFT = 5'(STEP);

  function automatic lane_t rotate(input lane_t a);
    lane_t o;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] t;
    dx = a.y >>> SHIFT;
    dy = a.x >>> SHIFT;
    t  = atan_entry(SHIFT);
    if (!a.z[33]) begin
      o.x = a.x - dx;
      o.y = a.y + dy;
      o.z = a.z - t;
    end else begin
      o.x = a.x + dx;
      o.y = a.y - dy;
      o.z = a.z + t;
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.r <= rotate(din.r);
    dout.p <= rotate(din.p);
    dout.w <= rotate(din.w);
  end

endmodule

// ===== src/e2q_combine.sv =====
// Pipelined triple products, sums and output rounding of the quaternion.
module e2q_combine #(
  parameter int OUT_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  e2q_pkg::cell_t              din,
  output logic                        valid,
  output logic signed [OUT_WIDTH-1:0] quat_w,
  output logic signed [OUT_WIDTH-1:0] quat_x,
  output logic signed [OUT_WIDTH-1:0] quat_y,
  output logic signed [OUT_WIDTH-1:0] quat_z
);
  import e2q_pkg::*;

  localparam int RS = (OUT_WIDTH <= 31) ? 31 - OUT_WIDTH : 0;
  localparam logic signed [34:0] HALF = (RS == 0) ? 35'sd0 : (35'sd1 <<< (RS - 1));
  localparam logic signed [34:0] HI = (35'sd1 <<< (OUT_WIDTH - 1)) - 35'sd1;
  localparam logic signed [34:0] LO = -HI - 35'sd1;

  function automatic logic signed [33:0] fmul(input logic signed [33:0] a,
                                              input logic signed [33:0] b);
    logic signed [67:0] p;
    p = a * b;
    return p[63:30];
  endfunction

  function automatic logic signed [OUT_WIDTH-1:0] to_out(input logic signed [34:0] v);
    logic signed [35:0] s;
    logic signed [35:0] r;
    s = 36'(v) + 36'(HALF);
    if (OUT_WIDTH <= 31) r = s >>> RS;
    else                 r = 36'(v) <<< 1;
    if (r > 36'(HI))      r = 36'(HI);
    else if (r < 36'(LO)) r = 36'(LO);
    return r[OUT_WIDTH-1:0];
  endfunction

  // Stage one: pair products of roll and pitch, yaw terms carried along.
  logic               v1;
  logic signed [33:0] cc, cs, sc, ss, cy1, sy1;
  // Stage two: the eight triple products.
  logic               v2;
  logic signed [33:0] ccc, sss, scc, css, csc, scs, ccs, ssc;
  // Stage three: sums.
  logic               v3;
  logic signed [34:0] sw, sx, sy, sz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      valid <= 1'b0;
    end else begin
      v1 <= din.valid;
      v2 <= v1;
      v3 <= v2;
      valid <= v3;
    end
    cc  <= fmul(din.r.x, din.p.x);
    cs  <= fmul(din.r.x, din.p.y);
    sc  <= fmul(din.r.y, din.p.x);
    ss  <= fmul(din.r.y, din.p.y);
    cy1 <= din.w.x;
    sy1 <= din.w.y;
    ccc <= fmul(cc, cy1);
    sss <= fmul(ss, sy1);
    scc <= fmul(sc, cy1);
    css <= fmul(cs, sy1);
    csc <= fmul(cs, cy1);
    scs <= fmul(sc, sy1);
    ccs <= fmul(cc, sy1);
    ssc <= fmul(ss, cy1);
    sw  <= 35'(ccc) + 35'(sss);
    sx  <= 35'(scc) - 35'(css);
    sy  <= 35'(csc) + 35'(scs);
    sz  <= 35'(ccs) - 35'(ssc);
    quat_w <= to_out(sw);
    quat_x <= to_out(sx);
    quat_y <= to_out(sy);
    quat_z <= to_out(sz);
  end

endmodule
